// File: rtl/core/smos_pkg.sv
package smos_pkg;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] TRIG_C1 = 32'd1686629713;
    localparam logic [31:0] TRIG_C3 = 32'd693598563;
    localparam logic [31:0] TRIG_C5 = 32'd80710674;

    // Angle table size per turn (a power of two) and stored range width.
    localparam int ANGLE_STEPS = 4096;
    localparam int RANGE_BITS  = 16;

    localparam logic [2:0] REG_ANGLE_STEP = 3'd0;
    localparam logic [2:0] REG_RANGE_STEP = 3'd1;
    localparam logic [2:0] REG_K_MIN      = 3'd2;
    localparam logic [2:0] REG_K_MAX      = 3'd3;
    localparam logic [2:0] REG_L_MIN      = 3'd4;
    localparam logic [2:0] REG_L_MAX      = 3'd5;

    // Datapath commands from the controller.
    typedef struct packed {
        logic load;      // write one beam into the stores
        logic pair_init; // clear accumulator, start beam walk for current k,l
        logic search_clr;// clear stored beam count when the result is taken
    } smos_cmd_t;

    // Datapath status back to the controller.
    typedef struct packed {
        logic pair_done; // accumulator holds the full sum for current k,l
        logic busy;      // pipeline still holds beams in flight
    } smos_sts_t;

endpackage

// File: rtl/core/scan_match_offset_search.sv
// Channel   | Dir | Beat fields
// s_axis    | in  | tdata: ref_range[15:0], obj_range[31:16]; tlast: last
// m_axis    | out | tdata: best_angle_offset[11:0], best_range_offset[20:12],
//           |     |        min_distance[84:21]; tuser: found
// cfg       | in  | cfg_we, cfg_addr (register index), cfg_wdata
// Beams load at one per cycle while no search or result is pending. After the
// last beam, each (k,l) pair walks all N beams through the memory read and a
// read/trig/square pipeline; pairs are searched one after another.
// The result beat waits in its register until taken; no beam is taken meanwhile.
// Reset is asynchronous active low and needs no clearing pass.
module scan_match_offset_search
    import smos_pkg::*;
#(
    parameter int MAX_POINTS  = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // ref_range, obj_range
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // best_angle_offset, best_range_offset, min_distance
    output logic        m_axis_tuser,  // found
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata
);

    logic [11:0] angle_step_reg;
    logic [7:0]  range_step_reg;
    logic signed [11:0] k_min_reg, k_max_reg, cur_k, best_k;
    logic signed [8:0]  l_min_reg, l_max_reg, cur_l, best_l;
    logic [63:0] pair_sum, best_sum;
    logic        found, s_beat;
    smos_cmd_t   cmd;
    smos_sts_t   sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_step_reg <= 12'd1;
            range_step_reg <= 8'd1;
            k_min_reg <= '0; k_max_reg <= 12'sd1;
            l_min_reg <= '0; l_max_reg <= 9'sd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ANGLE_STEP: angle_step_reg <= cfg_wdata;
                REG_RANGE_STEP: range_step_reg <= cfg_wdata[7:0];
                REG_K_MIN:      k_min_reg <= cfg_wdata;
                REG_K_MAX:      k_max_reg <= cfg_wdata;
                REG_L_MIN:      l_min_reg <= cfg_wdata[8:0];
                REG_L_MAX:      l_max_reg <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    assign s_beat = s_axis_tvalid && s_axis_tready;

    smos_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_beat(s_beat), .s_last(s_axis_tlast),
        .m_tready(m_axis_tready), .sts(sts), .k_min(k_min_reg), .k_max(k_max_reg),
        .l_min(l_min_reg), .l_max(l_max_reg), .pair_sum(pair_sum), .cmd(cmd),
        .s_ready(s_axis_tready), .m_valid(m_axis_tvalid), .cur_k(cur_k),
        .cur_l(cur_l), .found(found), .best_k(best_k), .best_l(best_l),
        .best_sum(best_sum));

    smos_datapath #(
        .MAX_POINTS(MAX_POINTS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .ref_range(s_axis_tdata[15:0]), .obj_range(s_axis_tdata[31:16]),
        .angle_step(angle_step_reg), .range_step(range_step_reg),
        .cur_k(cur_k), .cur_l(cur_l), .pair_sum(pair_sum));

    assign m_axis_tdata = {3'b0, best_sum, best_l, best_k};
    assign m_axis_tuser = found;

    a_no_load_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    a_empty_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[84:21] == ALL_ONES))
        else $error("empty search without sentinel distance");
    a_result_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result repeated");

endmodule

// File: rtl/core/smos_ram.sv
module smos_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/smos_sine.sv
// Pipelined Q1.15 sine of a Q32 turn fraction; one multiply per stage.
module smos_sine
    import smos_pkg::*;
(
    input  logic               clk,
    input  logic [31:0]        f,
    output logic signed [16:0] sine
);

    logic [1:0]  q1_reg, q2_reg, q3_reg, q4_reg, q5_reg;
    logic [30:0] x1_reg, x2x_reg, x3_reg, x4_reg;
    logic [30:0] xx_reg;
    logic [30:0] xx4_reg;
    logic [31:0] t3_reg, t4_reg;
    logic [31:0] s5_reg;
    logic [30:0] x_c;
    logic [61:0] xx_c;
    logic [62:0] p3_c;
    logic [62:0] p4_c;
    logic [61:0] p5_c;
    logic [31:0] v_c;
    logic [15:0] m_c;

    always_comb
    begin
        x_c = {1'b0, f[29:0]};
        if (f[30])
        begin
            x_c = 31'h4000_0000 - {1'b0, f[29:0]};
        end
    end

    assign xx_c = x1_reg * x1_reg;
    assign p3_c = xx_reg * TRIG_C5;
    assign p4_c = xx4_reg * t3_reg;
    assign p5_c = x4_reg * t4_reg[30:0];

    always_ff @(posedge clk)
    begin
        q1_reg  <= f[31:30];
        x1_reg  <= x_c;
        q2_reg  <= q1_reg;
        x2x_reg <= x1_reg;
        xx_reg  <= xx_c[60:30];
        q3_reg  <= q2_reg;
        x3_reg  <= x2x_reg;
        xx4_reg <= xx_reg;
        t3_reg  <= TRIG_C3 - 32'(p3_c >> 30);
        q4_reg  <= q3_reg;
        x4_reg  <= x3_reg;
        t4_reg  <= TRIG_C1 - 32'(p4_c >> 30);
        q5_reg  <= q4_reg;
        s5_reg  <= 32'(p5_c >> 30);
    end

    // the stage-3/4 x^2 register must follow its multiplicand
    always_comb
    begin
        v_c = (s5_reg + 32'd16384) >> 15;
        m_c = (v_c > 32'd32767) ? 16'd32767 : v_c[15:0];
        sine = q5_reg[1] ? -$signed({1'b0, m_c}) : $signed({1'b0, m_c});
    end

endmodule

// File: rtl/core/smos_datapath.sv
module smos_datapath
    import smos_pkg::*;
#(
    parameter int MAX_POINTS  = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  smos_cmd_t          cmd,
    output smos_sts_t          sts,
    input  logic [15:0]        ref_range,
    input  logic [15:0]        obj_range,
    input  logic [11:0]        angle_step,
    input  logic [7:0]         range_step,
    input  logic signed [11:0] cur_k,
    input  logic signed [8:0]  cur_l,
    output logic [63:0]        pair_sum
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SW  = $clog2(ANGLE_STEPS);
    localparam int LAT = 8;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg;
    logic          walk_reg;
    logic [SW-1:0] aref_reg, aobj_reg;
    logic [LAT-1:0] vld_reg;
    logic [63:0]   acc_reg;
    logic [15:0]   ref_rd, obj_rd;
    logic [15:0]   rmask;
    logic [AW-1:0] waddr, raddr;
    logic          we;
    logic signed [16:0] sr, cr, so, co;
    logic signed [17:0] loff_reg;
    logic [15:0]   r1_reg, r2_reg, r3_reg, r4_reg;
    logic signed [17:0] o1_reg, o2_reg, o3_reg, o4_reg;
    logic signed [34:0] ppx_reg, ppy_reg, prx_reg, pry_reg;
    logic signed [35:0] dx_c, dy_c;
    logic [35:0]   mx_c, my_c;
    logic [24:0]   qx_reg, qy_reg;
    logic [49:0]   sqx_reg, sqy_reg;
    logic [50:0]   sq_c;
    logic [64:0]   acc_c;
    logic [31:0]   fref, fobj;
    logic [SW-1:0] kstep;
    logic [SW+11:0] kprod;

    assign rmask = 16'((17'd1 << RANGE_BITS) - 17'd1);
    assign we    = cmd.load && (count_reg < CW'(MAX_POINTS));
    assign waddr = count_reg[AW-1:0];
    assign raddr = idx_reg[AW-1:0];

    smos_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_ref (
        .clk(clk), .we(we), .waddr(waddr), .wdata(ref_range & rmask),
        .raddr(raddr), .rdata(ref_rd));
    smos_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_obj (
        .clk(clk), .we(we), .waddr(waddr), .wdata(obj_range & rmask),
        .raddr(raddr), .rdata(obj_rd));

    // Turn fraction: index * 2^32 / ANGLE_STEPS, exact since ANGLE_STEPS is 2^SW.
    assign fref = {aref_reg, {(32-SW){1'b0}}};
    assign fobj = {aobj_reg, {(32-SW){1'b0}}};

    smos_sine u_sr (.clk(clk), .f(fref), .sine(sr));
    smos_sine u_cr (.clk(clk), .f(fref + 32'h4000_0000), .sine(cr));
    smos_sine u_so (.clk(clk), .f(fobj), .sine(so));
    smos_sine u_co (.clk(clk), .f(fobj + 32'h4000_0000), .sine(co));

    assign kprod = $signed({{SW{cur_k[11]}}, cur_k}) * $signed({1'b0, angle_step});
    assign kstep = kprod[SW-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (we)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.search_clr)
        begin
            count_next = '0;
        end
    end

    assign dx_c = 36'(ppx_reg) - 36'(prx_reg);
    assign dy_c = 36'(ppy_reg) - 36'(pry_reg);
    assign mx_c = dx_c[35] ? 36'(-dx_c) : 36'(dx_c);
    assign my_c = dy_c[35] ? 36'(-dy_c) : 36'(dy_c);
    assign sq_c = 51'(sqx_reg) + 51'(sqy_reg);
    assign acc_c = 65'(acc_reg) + 65'(sq_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            walk_reg  <= 1'b0;
            vld_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            vld_reg   <= {vld_reg[LAT-2:0], walk_reg};
            if (cmd.pair_init)
            begin
                idx_reg  <= '0;
                walk_reg <= (count_reg != '0);
            end
            else if (walk_reg)
            begin
                idx_reg  <= idx_reg + CW'(1);
                walk_reg <= (idx_reg + CW'(1)) < count_reg;
            end
        end
    end

    // Beam walk: RAM read and angle index follow idx; ranges delayed to match sine pipe.
    always_ff @(posedge clk)
    begin
        if (cmd.pair_init)
        begin
            aref_reg <= '0;
            aobj_reg <= kstep;
            loff_reg <= 18'($signed(cur_l) * $signed({1'b0, range_step}));
            acc_reg  <= '0;
        end
        else
        begin
            if (walk_reg)
            begin
                aref_reg <= aref_reg + angle_step[SW-1:0];
                aobj_reg <= aobj_reg + angle_step[SW-1:0];
            end
            if (vld_reg[LAT-1])
            begin
                acc_reg <= acc_c[64] ? ALL_ONES : acc_c[63:0];
            end
        end
        r1_reg  <= ref_rd;
        o1_reg  <= $signed({2'b0, obj_rd}) + loff_reg;
        r2_reg  <= r1_reg;  o2_reg <= o1_reg;
        r3_reg  <= r2_reg;  o3_reg <= o2_reg;
        r4_reg  <= r3_reg;  o4_reg <= o3_reg;
        ppx_reg <= o4_reg * co;
        ppy_reg <= o4_reg * so;
        prx_reg <= $signed({1'b0, r4_reg}) * cr;
        pry_reg <= $signed({1'b0, r4_reg}) * sr;
        qx_reg  <= 25'((mx_c + 36'd1024) >> 11);
        qy_reg  <= 25'((my_c + 36'd1024) >> 11);
        sqx_reg <= qx_reg * qx_reg;
        sqy_reg <= qy_reg * qy_reg;
    end

    assign pair_sum      = acc_reg;
    assign sts.busy      = walk_reg || (vld_reg != '0);
    assign sts.pair_done = !sts.busy;

endmodule

// File: rtl/core/smos_ctrl.sv
module smos_ctrl
    import smos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_beat,
    input  logic               s_last,
    input  logic               m_tready,
    input  smos_sts_t          sts,
    input  logic signed [11:0] k_min,
    input  logic signed [11:0] k_max,
    input  logic signed [8:0]  l_min,
    input  logic signed [8:0]  l_max,
    input  logic [63:0]        pair_sum,
    output smos_cmd_t          cmd,
    output logic               s_ready,
    output logic               m_valid,
    output logic signed [11:0] cur_k,
    output logic signed [8:0]  cur_l,
    output logic               found,
    output logic signed [11:0] best_k,
    output logic signed [8:0]  best_l,
    output logic [63:0]        best_sum
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic signed [11:0] k_reg, k_next;
    logic signed [8:0]  l_reg, l_next;
    logic found_reg, found_next;
    logic signed [11:0] bk_reg, bk_next;
    logic signed [8:0]  bl_reg, bl_next;
    logic [63:0] bs_reg, bs_next;
    logic wait_reg, wait_next;

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg; l_next = l_reg;
        found_next = found_reg; bk_next = bk_reg; bl_next = bl_reg; bs_next = bs_reg;
        wait_next = 1'b0;
        cmd = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_beat)
                begin
                    cmd.load = 1'b1;
                    if (s_last)
                    begin
                        found_next = 1'b0; bk_next = '0; bl_next = '0; bs_next = ALL_ONES;
                        k_next = k_min; l_next = l_min;
                        state_next = ((k_min < k_max) && (l_min < l_max)) ? ST_START : ST_OUT;
                    end
                end
            end
            ST_START:
            begin
                cmd.pair_init = 1'b1;
                wait_next = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!wait_reg && sts.pair_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!found_reg || (pair_sum < bs_reg))
                begin
                    found_next = 1'b1; bs_next = pair_sum; bk_next = k_reg; bl_next = l_reg;
                end
                state_next = ST_START;
                if (l_reg + 9'sd1 < l_max)
                begin
                    l_next = l_reg + 9'sd1;
                end
                else if (k_reg + 12'sd1 < k_max)
                begin
                    l_next = l_min; k_next = k_reg + 12'sd1;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    cmd.search_clr = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            k_reg <= '0; l_reg <= '0;
            found_reg <= 1'b0; bk_reg <= '0; bl_reg <= '0; bs_reg <= ALL_ONES;
            wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next; l_reg <= l_next;
            found_reg <= found_next; bk_reg <= bk_next; bl_reg <= bl_next;
            bs_reg <= bs_next;
            wait_reg <= wait_next;
        end
    end

    assign s_ready  = (state_reg == ST_LOAD);
    assign m_valid  = (state_reg == ST_OUT);
    assign cur_k    = k_reg;
    assign cur_l    = l_reg;
    assign found    = found_reg;
    assign best_k   = bk_reg;
    assign best_l   = bl_reg;
    assign best_sum = bs_reg;

endmodule
